FILE: design/sha256bh_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash: shared package
// Word type, round constants, initial hash values, round functions and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package sha256bh_pkg;

	localparam int WORD_W       = 32;
	localparam int DIGEST_WORDS = 8;
	localparam int BLOCK_WORDS  = 16;
	localparam int ROUNDS       = 64;
	localparam int IDX_W        = $clog2(DIGEST_WORDS);
	localparam int WCNT_W       = $clog2(BLOCK_WORDS);
	localparam int RND_W        = $clog2(ROUNDS);

	localparam logic [IDX_W-1:0]  DIGEST_LAST = IDX_W'(DIGEST_WORDS - 1);
	localparam logic [WCNT_W-1:0] WORD_LAST   = WCNT_W'(BLOCK_WORDS - 1);
	localparam logic [RND_W-1:0]  ROUND_LAST  = RND_W'(ROUNDS - 1);

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t HASH_IV [DIGEST_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic              load;
		logic              new_msg;
		logic              init_vars;
		logic              round;
		logic [RND_W-1:0]  rnd_idx;
		logic              add;
		logic              emit;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

	function automatic word_t rotr(input word_t v, input int n);
		return (v >> n) | (v << (WORD_W - n));
	endfunction

	function automatic word_t big_sigma0(input word_t v);
		return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
	endfunction

	function automatic word_t big_sigma1(input word_t v);
		return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
	endfunction

	function automatic word_t small_sigma0(input word_t v);
		return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
	endfunction

	function automatic word_t small_sigma1(input word_t v);
		return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
	endfunction

	function automatic word_t choose(input word_t e, input word_t f, input word_t g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic word_t majority(input word_t a, input word_t b, input word_t c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

FILE: design/sha256bh_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash: controller
// Counts words into a block, sequences the 64 rounds, the chaining add and
// the hand-over of the digest to the output buffer.
// ----------------------------------------------------------------------------
module sha256bh_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_new_msg,
	input  logic                in_final,
	output logic                in_ready,
	input  sha256bh_pkg::sts_t  sts,
	output sha256bh_pkg::cmd_t  cmd
);
	import sha256bh_pkg::*;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_ROUND = 2'd1;
	localparam logic [1:0] ST_ADD   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]        state_q;
	logic [WCNT_W-1:0] word_cnt_q;
	logic [RND_W-1:0]  rnd_cnt_q;
	logic              final_q;
	logic              acc;
	logic [WCNT_W-1:0] eff_cnt;

	assign in_ready = (state_q == ST_LOAD);
	assign acc      = in_valid && in_ready;
	assign eff_cnt  = in_new_msg ? '0 : word_cnt_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = acc;
		cmd.new_msg   = acc && in_new_msg;
		cmd.init_vars = acc && (eff_cnt == WORD_LAST);
		cmd.round     = (state_q == ST_ROUND);
		cmd.rnd_idx   = rnd_cnt_q;
		cmd.add       = (state_q == ST_ADD);
		cmd.emit      = (state_q == ST_EMIT) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			word_cnt_q <= '0;
			rnd_cnt_q  <= '0;
			final_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (eff_cnt == WORD_LAST) begin
							word_cnt_q <= '0;
							rnd_cnt_q  <= '0;
							final_q    <= in_final;
							state_q    <= ST_ROUND;
						end else begin
							word_cnt_q <= eff_cnt + 1'b1;
						end
					end
				end
				ST_ROUND: begin
					rnd_cnt_q <= rnd_cnt_q + 1'b1;
					if (rnd_cnt_q == ROUND_LAST) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					state_q <= final_q ? ST_EMIT : ST_LOAD;
				end
				ST_EMIT: begin
					if (!sts.out_busy) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

FILE: design/sha256bh_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash: datapath
// Rolling message schedule window, working variables a..h, chaining value
// and an eight-word digest buffer that drains to the output channel.
// ----------------------------------------------------------------------------
module sha256bh_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sha256bh_pkg::cmd_t             cmd,
	output sha256bh_pkg::sts_t             sts,
	input  sha256bh_pkg::word_t            in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output sha256bh_pkg::word_t            out_word,
	output logic [sha256bh_pkg::IDX_W-1:0] out_idx,
	output logic                           out_last
);
	import sha256bh_pkg::*;

	word_t            win_q [BLOCK_WORDS];
	word_t            v_q   [DIGEST_WORDS];
	word_t            cv_q  [DIGEST_WORDS];
	word_t            ob_q  [DIGEST_WORDS];
	logic [IDX_W-1:0] out_idx_q;
	logic             out_vld_q;
	word_t            w_next;
	word_t            t1;
	word_t            t2;

	assign w_next = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
	assign t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
		+ ROUND_K[cmd.rnd_idx] + win_q[0];
	assign t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.round) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BLOCK_WORDS-1] <= cmd.load ? in_word : w_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				v_q[i]  <= '0;
				cv_q[i] <= HASH_IV[i];
			end
		end else begin
			if (cmd.init_vars) begin
				for (int i = 0; i < DIGEST_WORDS; i++) begin
					v_q[i] <= cv_q[i];
				end
			end else if (cmd.round) begin
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			if (cmd.new_msg) begin
				for (int i = 0; i < DIGEST_WORDS; i++) begin
					cv_q[i] <= HASH_IV[i];
				end
			end else if (cmd.add) begin
				for (int i = 0; i < DIGEST_WORDS; i++) begin
					cv_q[i] <= cv_q[i] + v_q[i];
				end
			end
		end
	end

	// digest buffer: shift one word out per beat
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				ob_q[i] <= cv_q[i];
			end
		end else if (out_vld_q && out_ready) begin
			for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
				ob_q[i] <= ob_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_idx_q <= '0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
			out_idx_q <= '0;
		end else if (out_vld_q && out_ready) begin
			out_idx_q <= out_idx_q + 1'b1;
			if (out_idx_q == DIGEST_LAST) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign sts.out_busy = out_vld_q;
	assign out_valid    = out_vld_q;
	assign out_word     = ob_q[0];
	assign out_idx      = out_idx_q;
	assign out_last     = (out_idx_q == DIGEST_LAST);

endmodule

FILE: design/sha256_block_hash_core.sv
// ----------------------------------------------------------------------------
// SHA-256 block hash core
// Hashes a host-padded message given as 32-bit big-endian words and returns
// the eight digest words after each block marked final.
// ----------------------------------------------------------------------------
// Input channel s_axis: one message word per beat; tuser set marks the first
// word of a new message, tlast on the sixteenth word of a block marks the
// last block. Output channel m_axis: eight digest words, index 0 (most
// significant) first, tlast on index 7.
// s_axis_tready is high while a block fills. The sixteenth word starts the
// compression: 64 rounds at one per cycle through the single round unit and
// the rolling schedule, then the chaining add; a final block then passes an
// emit state that hands the digest to the output buffer. s_axis_tready is
// low during compression.
// The digest buffer drains independently; if the receiver stalls, words hold
// and the next block fills, but its digest waits until the buffer is empty.
// First digest word follows the final block's rounds, chaining add and emit.
// Reset loads the standard initial hash values, clears the word and round
// counts and empties the digest buffer.
// ----------------------------------------------------------------------------
module sha256_block_hash_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,  // [31:0] message_word
	input  logic [0:0]                 s_axis_tuser,  // [0] command
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [31:0]                m_axis_tdata,  // [31:0] digest_word
	output logic [2:0]                 m_axis_tuser,  // [2:0] digest_index
	output logic                       m_axis_tlast
);
	import sha256bh_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sha256bh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_new_msg (s_axis_tuser[0]),
		.in_final   (s_axis_tlast),
		.in_ready   (s_axis_tready),
		.sts        (sts),
		.cmd        (cmd)
	);

	sha256bh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (m_axis_tdata),
		.out_idx   (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

`ifndef NO_ASSERTIONS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.out_busy)
		else $error("digest loaded into a busy output buffer");

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.round, cmd.add, cmd.emit}))
		else $error("more than one datapath operation at once");

	a_add_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.round && cmd.rnd_idx == ROUND_LAST) |=> cmd.add)
		else $error("chaining add does not follow the last round");

	a_no_input_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.round |-> !s_axis_tready)
		else $error("input accepted during compression");
`endif

endmodule

FILE: test/sha256_block_hash_core_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 block hash core: stream checker
// Watches both stream channels of the core. Every accepted message word is
// fed through an independent SHA-256 block predictor that keeps its own
// chaining value, schedule window and word count; each final block queues
// eight digest beats, which are compared in order, field by field, with the
// beats the core delivers. Counts of failures, outstanding beats and
// compared beats go back to the testbench top.
// ----------------------------------------------------------------------------
module sha256_block_hash_core_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] message_word
	input  logic [0:0]  s_tuser,  // [0] command
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,  // [31:0] digest_word
	input  logic [2:0]  m_tuser,  // [2:0] digest_index
	input  logic        m_tlast,
	output int          fails,
	output int          pending,
	output int          checked
);
	import sha256bh_pkg::*;

	typedef struct {
		word_t      word;
		logic [2:0] index;
		logic       last;
	} digest_beat_t;

	digest_beat_t digest_q[$];
	word_t        chain[DIGEST_WORDS];
	word_t        window[BLOCK_WORDS];
	logic [3:0]   fill;

	function automatic word_t ror(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t sum0(input word_t x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic word_t sum1(input word_t x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic word_t expand0(input word_t x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t expand1(input word_t x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	task automatic compress_window();
		word_t sched[ROUNDS];
		word_t v[8];
		word_t t1;
		word_t t2;
		for (int t = 0; t < BLOCK_WORDS; t++)
			sched[t] = window[t];
		for (int t = BLOCK_WORDS; t < ROUNDS; t++)
			sched[t] = expand1(sched[t-2]) + sched[t-7] + expand0(sched[t-15]) + sched[t-16];
		for (int i = 0; i < 8; i++)
			v[i] = chain[i];
		for (int r = 0; r < ROUNDS; r++) begin
			t1 = v[7] + sum1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
				+ ROUND_K[r] + sched[r];
			t2 = sum0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endtask

	task automatic absorb_word(input logic new_msg, input word_t data, input logic fin);
		digest_beat_t beat;
		if (new_msg) begin
			chain = HASH_IV;
			fill  = '0;
		end
		window[fill] = data;
		if (fill != WORD_LAST) begin
			fill = fill + 4'd1;
		end else begin
			fill = '0;
			compress_window();
			if (fin) begin
				for (int i = 0; i < DIGEST_WORDS; i++) begin
					beat.word  = chain[i];
					beat.index = 3'(i);
					beat.last  = (i == DIGEST_WORDS - 1);
					digest_q   = {digest_q, beat};
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		digest_beat_t want;
		if (!arst_n) begin
			chain = HASH_IV;
			fill  = '0;
			foreach (window[i])
				window[i] = '0;
			digest_q.delete();
			fails   = 0;
			pending = 0;
			checked = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected digest beat, expected none, %s %h index %0d last %b",
						$time, "actual word", m_tdata, m_tuser, m_tlast);
				end else begin
					want = digest_q.pop_front();
					checked++;
					if (m_tdata !== want.word || m_tuser !== want.index
							|| m_tlast !== want.last) begin
						fails++;
						$display("%0t: digest beat, expected word %h index %0d last %b,",
							$time, want.word, want.index, want.last,
							" actual word %h index %0d last %b",
							m_tdata, m_tuser, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready)
				absorb_word(s_tuser[0], s_tdata, s_tlast);
			pending = digest_q.size();
		end
	end

endmodule

FILE: test/sha256_block_hash_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 block hash core: testbench top
// Drives message words into the core: a directed block of edge-case
// words, then random messages of one to four blocks, with truncated blocks,
// stray last flags and chained messages mixed in. Runs through phases of
// sender idling and receiver stalling, one long output hold-off and a pause
// for the pipeline to drain, then reports the verdict from the checker.
// ----------------------------------------------------------------------------
module sha256_block_hash_core_tb;
	import sha256bh_pkg::*;

	localparam logic CMD_NEXT     = 1'b0;
	localparam logic CMD_NEW      = 1'b1;
	localparam int   HOLD_CYCLES  = 400;
	localparam int   DRAIN_CYCLES = 100;
	localparam int   CYCLE_LIMIT  = 200000;
	localparam int   PHASE_WORDS  = 24;

	localparam word_t EDGE_WORDS [BLOCK_WORDS] = '{
		32'h00000000, 32'hffffffff, 32'h80000000, 32'h00000001,
		32'haaaaaaaa, 32'h55555555, 32'hffffffff, 32'h00000000,
		32'h7fffffff, 32'hfffffffe, 32'h00000000, 32'hffffffff,
		32'h80000000, 32'h00000000, 32'h00000000, 32'h00000200
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int fails;
	int pending;
	int checked;
	int idle_pct;
	int stall_pct;
	int hold_req;
	int hold_seen;
	int words_sent;
	int messages_sent;

	sha256_block_hash_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.s_axis_tlast  (s_tlast),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast)
	);

	sha256_block_hash_core_check i_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.fails    (fails),
		.pending  (pending),
		.checked  (checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("sha256_block_hash_core: mismatch");
		$finish;
	end

	// hold off the digest for a long stretch on request, otherwise stall at random
	initial begin
		m_tready  = 1'b0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic send_word(input logic cmd, input word_t data, input logic fin);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= cmd;
		s_tlast  <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		words_sent++;
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	// cut > 0 abandons the message after that many words
	task automatic send_message(input int blocks, input logic start, input logic is_final,
			input int cut);
		int   total;
		logic cmd;
		logic fin;
		total = (cut > 0) ? cut : blocks * BLOCK_WORDS;
		for (int n = 0; n < total; n++) begin
			cmd = (n == 0) ? start : CMD_NEXT;
			if (n % BLOCK_WORDS != BLOCK_WORDS - 1)
				fin = ($urandom_range(0, 9) == 0);
			else if (n / BLOCK_WORDS == blocks - 1)
				fin = is_final;
			else
				fin = ($urandom_range(0, 7) == 0);
			send_word(cmd, pick_word(), fin);
		end
		messages_sent++;
	endtask

	task automatic random_message();
		int   blocks;
		logic start;
		logic fin;
		int   cut;
		blocks = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
		start  = ($urandom_range(0, 99) < 85) ? CMD_NEW : CMD_NEXT;
		fin    = ($urandom_range(0, 99) < 90);
		cut    = ($urandom_range(0, 99) < 10) ? $urandom_range(1, blocks * BLOCK_WORDS - 1) : 0;
		send_message(blocks, start, fin, cut);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int idle, input int stall);
		int start;
		idle_pct  = idle;
		stall_pct = stall;
		start     = words_sent;
		while (words_sent - start < PHASE_WORDS)
			random_message();
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = CMD_NEXT;
		s_tlast       = 1'b0;
		idle_pct      = 0;
		stall_pct     = 0;
		hold_req      = 0;
		words_sent    = 0;
		messages_sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first message straight after reset, no new-message command, stray last on word 3
		for (int n = 0; n < BLOCK_WORDS; n++)
			send_word(CMD_NEXT, EDGE_WORDS[n], (n == 3) || (n == BLOCK_WORDS - 1));
		messages_sent++;
		// partial block, dropped by the next new message
		send_word(CMD_NEW, '1, 1'b0);
		send_word(CMD_NEXT, '0, 1'b1);
		send_word(CMD_NEXT, '1, 1'b0);
		drain();

		// long hold-off: digest buffer fills, the next block waits, input stalls
		hold_req++;
		repeat (3) send_message(1, CMD_NEW, 1'b1, 0);
		drain();

		run_phase(0, 0);
		run_phase(73, 0);
		run_phase(0, 73);
		run_phase(14, 14);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d words in %0d messages over four idle and stall phases",
			words_sent, messages_sent);
		$display("with one long output hold-off; %0d digest beats compared", checked);
		if (fails == 0 && pending == 0)
			$display("sha256_block_hash_core: match");
		else
			$display("sha256_block_hash_core: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
design/sha256bh_pkg.sv
design/sha256bh_ctrl.sv
design/sha256bh_dp.sv
design/sha256_block_hash_core.sv
test/sha256_block_hash_core_check.sv
test/sha256_block_hash_core_tb.sv
